>>> design/baro_pressure_temp_compensation_unit_assert.svh
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_UNIT_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_UNIT_ASSERT_SVH

// check on every clock edge, reset included
`define BPTC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

// check only while out of reset
`define BPTC_ASSERT_RUN(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`endif

>>> design/bptc_pkg.sv
package bptc_pkg;

  localparam int CAL_W     = 16;
  localparam int RAW_W     = 24;
  localparam int CFG_IDX_W = 3;
  localparam int TEMP_W    = 19;
  localparam int PRESS_W   = 23;
  localparam int DATA_IN_W  = 48;
  localparam int DATA_OUT_W = 48;

  localparam int DT_W   = RAW_W + 1;
  localparam int PROD_W = DT_W + CAL_W;
  localparam int OFF_W  = 35;
  localparam int SENS_W = 34;
  localparam int SENS_LO_W = 17;
  localparam int FULL_W = 58;
  localparam int Q_W    = 37;
  localparam int DIFF_W = 38;

  localparam int SH_TEMP      = 23;
  localparam int SH_OFF_BASE  = 16;
  localparam int SH_OFF_TC    = 7;
  localparam int SH_SENS_BASE = 15;
  localparam int SH_SENS_TC   = 8;
  localparam int SH_P_MUL     = 21;
  localparam int SH_P_OUT     = 15;
  localparam int SH_REF       = 8;

  localparam logic [TEMP_W-1:0] TEMP_BASE = TEMP_W'(2000);

  localparam logic [CFG_IDX_W-1:0] REG_PRESS_SENS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESS_OFF  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SENS_TC    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFF_TC     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TEMP_COEFF = 3'd5;

  typedef struct packed {
    logic [CAL_W-1:0] press_sens;
    logic [CAL_W-1:0] press_off;
    logic [CAL_W-1:0] sens_tc;
    logic [CAL_W-1:0] off_tc;
    logic [CAL_W-1:0] ref_temp;
    logic [CAL_W-1:0] temp_coeff;
  } cal_t;

endpackage

>>> design/baro_pressure_temp_compensation_unit.sv
// channel | dir | tdata fields (low bit up)                      | tuser | tlast
// in_     | in  | raw_pressure[23:0], raw_temperature[47:24]     | -     | -
// out_    | out | temperature_centideg[18:0], pressure_centimbar[41:19], pad | - | -
// cfg_    | in  | we, index[2:0], wdata[15:0]                    | -     | -
// One transaction enters per cycle unless a stalled output has backed up to stage 0.
// The pipeline has six register stages: dT, three products, offset and sensitivity,
// split pressure product, product sum, offset subtract.
// Each stage holds while the stage after it is full and stalled; bubbles close up.
// Synchronous reset clears all stage valids and the calibration words.
module baro_pressure_temp_compensation_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // raw_pressure[23:0], raw_temperature[47:24]
  input  logic [bptc_pkg::DATA_IN_W-1:0]  in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // temperature_centideg[18:0], pressure_centimbar[41:19], zero[47:42]
  output logic [bptc_pkg::DATA_OUT_W-1:0] out_tdata,
  input  logic                            cfg_we,
  input  logic [bptc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bptc_pkg::CAL_W-1:0]      cfg_wdata
);

  localparam int NSTG = 6;

  bptc_pkg::cal_t cal_r;

  bptc_cal_regs u_cal (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cal_r     (cal_r)
  );

  logic [NSTG-1:0] vld_r;
  logic [NSTG-1:0] vld_nxt;
  logic [NSTG:0]   rdy;

  always_comb begin
    rdy[NSTG] = out_tready;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  always_comb begin
    vld_nxt = vld_r;
    for (int i = 0; i < NSTG; i++) begin
      if (rdy[i]) begin
        vld_nxt[i] = (i == 0) ? in_tvalid : vld_r[(i == 0) ? 0 : i - 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = rdy[0];
  assign out_tvalid = vld_r[NSTG-1];

  // stage 0: temperature difference
  logic        [bptc_pkg::RAW_W-1:0] d1_0_r, d1_0_nxt;
  logic signed [bptc_pkg::DT_W-1:0]  dt_0_r, dt_0_nxt;

  always_comb begin
    d1_0_nxt = in_tdata[bptc_pkg::RAW_W-1:0];
    dt_0_nxt = $signed({1'b0, in_tdata[2*bptc_pkg::RAW_W-1:bptc_pkg::RAW_W]})
             - $signed({1'b0, cal_r.ref_temp, bptc_pkg::SH_REF'(0)});
  end

  // stage 1: products with dT
  logic        [bptc_pkg::RAW_W-1:0]  d1_1_r;
  logic signed [bptc_pkg::PROD_W-1:0] pt_1_r, pt_1_nxt;
  logic signed [bptc_pkg::PROD_W-1:0] po_1_r, po_1_nxt;
  logic signed [bptc_pkg::PROD_W-1:0] ps_1_r, ps_1_nxt;

  always_comb begin
    pt_1_nxt = dt_0_r * $signed({1'b0, cal_r.temp_coeff});
    po_1_nxt = dt_0_r * $signed({1'b0, cal_r.off_tc});
    ps_1_nxt = dt_0_r * $signed({1'b0, cal_r.sens_tc});
  end

  // stage 2: temperature, offset, sensitivity
  logic [bptc_pkg::RAW_W-1:0]  d1_2_r;
  logic [bptc_pkg::TEMP_W-1:0] temp_2_r, temp_2_nxt;
  logic [bptc_pkg::OFF_W-1:0]  off_2_r, off_2_nxt;
  logic [bptc_pkg::SENS_W-1:0] sens_2_r, sens_2_nxt;

  always_comb begin
    temp_2_nxt = {pt_1_r[bptc_pkg::PROD_W-1], pt_1_r[bptc_pkg::PROD_W-1:bptc_pkg::SH_TEMP]}
               + bptc_pkg::TEMP_BASE;
    off_2_nxt  = {3'b000, cal_r.press_off, bptc_pkg::SH_OFF_BASE'(0)}
               + {po_1_r[bptc_pkg::PROD_W-1], po_1_r[bptc_pkg::PROD_W-1:bptc_pkg::SH_OFF_TC]};
    sens_2_nxt = {3'b000, cal_r.press_sens, bptc_pkg::SH_SENS_BASE'(0)}
               + {ps_1_r[bptc_pkg::PROD_W-1], ps_1_r[bptc_pkg::PROD_W-1:bptc_pkg::SH_SENS_TC]};
  end

  // stage 3: pressure product as two partial products
  logic        [bptc_pkg::TEMP_W-1:0] temp_3_r;
  logic        [bptc_pkg::OFF_W-1:0]  off_3_r;
  logic        [bptc_pkg::PROD_W-1:0] pl_3_r, pl_3_nxt;
  logic signed [bptc_pkg::PROD_W-1:0] ph_3_r, ph_3_nxt;

  always_comb begin
    pl_3_nxt = bptc_pkg::PROD_W'(d1_2_r) * bptc_pkg::PROD_W'(sens_2_r[bptc_pkg::SENS_LO_W-1:0]);
    ph_3_nxt = $signed({1'b0, d1_2_r})
             * $signed(sens_2_r[bptc_pkg::SENS_W-1:bptc_pkg::SENS_LO_W]);
  end

  // stage 4: combine partial products
  logic [bptc_pkg::TEMP_W-1:0] temp_4_r;
  logic [bptc_pkg::OFF_W-1:0]  off_4_r;
  logic [bptc_pkg::Q_W-1:0]    q_4_r, q_4_nxt;
  logic [bptc_pkg::FULL_W-1:0] full;

  always_comb begin
    full    = {ph_3_r, bptc_pkg::SENS_LO_W'(0)} + {bptc_pkg::SENS_LO_W'(0), pl_3_r};
    q_4_nxt = full[bptc_pkg::FULL_W-1:bptc_pkg::SH_P_MUL];
  end

  // stage 5: subtract offset, output register
  logic [bptc_pkg::TEMP_W-1:0]  temp_5_r;
  logic [bptc_pkg::PRESS_W-1:0] press_5_r, press_5_nxt;
  logic [bptc_pkg::DIFF_W-1:0]  diff;

  always_comb begin
    diff = {q_4_r[bptc_pkg::Q_W-1], q_4_r}
         - {{3{off_4_r[bptc_pkg::OFF_W-1]}}, off_4_r};
    press_5_nxt = diff[bptc_pkg::DIFF_W-1:bptc_pkg::SH_P_OUT];
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      d1_0_r <= d1_0_nxt;
      dt_0_r <= dt_0_nxt;
    end
    if (rdy[1]) begin
      d1_1_r <= d1_0_r;
      pt_1_r <= pt_1_nxt;
      po_1_r <= po_1_nxt;
      ps_1_r <= ps_1_nxt;
    end
    if (rdy[2]) begin
      d1_2_r   <= d1_1_r;
      temp_2_r <= temp_2_nxt;
      off_2_r  <= off_2_nxt;
      sens_2_r <= sens_2_nxt;
    end
    if (rdy[3]) begin
      temp_3_r <= temp_2_r;
      off_3_r  <= off_2_r;
      pl_3_r   <= pl_3_nxt;
      ph_3_r   <= ph_3_nxt;
    end
    if (rdy[4]) begin
      temp_4_r <= temp_3_r;
      off_4_r  <= off_3_r;
      q_4_r    <= q_4_nxt;
    end
    if (rdy[5]) begin
      temp_5_r  <= temp_4_r;
      press_5_r <= press_5_nxt;
    end
  end

  assign out_tdata = {(bptc_pkg::DATA_OUT_W - bptc_pkg::PRESS_W - bptc_pkg::TEMP_W)'(0),
                      press_5_r, temp_5_r};

endmodule

>>> design/bptc_cal_regs.sv
module bptc_cal_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [bptc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bptc_pkg::CAL_W-1:0]     cfg_wdata,
  output bptc_pkg::cal_t                 cal_r
);

  bptc_pkg::cal_t cal_nxt;

  always_comb begin
    cal_nxt = cal_r;
    if (cfg_we) begin
      unique case (cfg_index)
        bptc_pkg::REG_PRESS_SENS: cal_nxt.press_sens = cfg_wdata;
        bptc_pkg::REG_PRESS_OFF:  cal_nxt.press_off  = cfg_wdata;
        bptc_pkg::REG_SENS_TC:    cal_nxt.sens_tc    = cfg_wdata;
        bptc_pkg::REG_OFF_TC:     cal_nxt.off_tc     = cfg_wdata;
        bptc_pkg::REG_REF_TEMP:   cal_nxt.ref_temp   = cfg_wdata;
        bptc_pkg::REG_TEMP_COEFF: cal_nxt.temp_coeff = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_r <= '0;
    end else begin
      cal_r <= cal_nxt;
    end
  end

endmodule

>>> design/bptc_checker.sv
`include "baro_pressure_temp_compensation_unit_assert.svh"

module bptc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [bptc_pkg::DATA_OUT_W-1:0] out_tdata
);

  `BPTC_ASSERT_ALWAYS(a_rst_empty, !rst_n |=> !out_tvalid, "output valid right after reset")

  `BPTC_ASSERT_RUN(a_out_hold, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled output changed")

  `BPTC_ASSERT_RUN(a_ready_empty, !out_tvalid |-> in_tready, "input stalled with empty output")

  `BPTC_ASSERT_RUN(a_temp_range, out_tvalid |-> ($signed(out_tdata[18:0]) >= -129072) && ($signed(out_tdata[18:0]) <= 133072) && (out_tdata[47:42] == 6'd0), "temperature out of range or pad set")

endmodule

bind baro_pressure_temp_compensation_unit bptc_checker u_bptc_checker (.*);
